@@ hw/rtl/btlpm_pkg.sv @@
// Shared types and constants for the binary trie longest-prefix-match block.
// Used by btlpm_ctrl, btlpm_dp and binary_trie_longest_prefix_match.
`timescale 1ns / 1ps

package btlpm_pkg;

    localparam int NODE_COUNT = 4096;
    localparam int ADDR_BITS  = 32;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int USED_W     = IDX_W + 1;
    localparam int DEPTH_W    = $clog2(ADDR_BITS + 1);
    localparam int LEN_W      = 6;
    localparam int PORT_W     = 8;

    localparam int LEN_LSB    = ADDR_BITS;
    localparam int RPORT_LSB  = LEN_LSB + LEN_W;
    localparam int IN_BITS    = RPORT_LSB + PORT_W;
    localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_BITS   = 1 + PORT_W + 1;
    localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef struct packed
    {
        logic              valid;
        logic [PORT_W-1:0] port;
        logic [IDX_W-1:0]  child1;
        logic [IDX_W-1:0]  child0;
    } node_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_WALK,
        ST_ALLOC,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        logic load;
        logic follow;
        logic alloc;
        logic commit;
        logic fill;
        logic fresh;
        logic record;
        logic set_full;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed
    {
        logic is_lookup;
        logic at_end;
        logic child_none;
        logic pool_full;
    } dp_sts_t;

endpackage

@@ hw/rtl/btlpm_ctrl.sv @@
// Controller state machine for the trie walk: decides follow, allocate,
// commit and finish per level. Depends on btlpm_pkg.
`timescale 1ns / 1ps

module btlpm_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  btlpm_pkg::dp_sts_t  sts,
    output btlpm_pkg::dp_cmd_t  cmd
);

    btlpm_pkg::state_t state_reg;
    btlpm_pkg::state_t state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == btlpm_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            btlpm_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = btlpm_pkg::ST_WALK;
                end
            end
            btlpm_pkg::ST_WALK:
            begin
                if (sts.is_lookup)
                begin
                    if (sts.at_end || sts.child_none)
                    begin
                        state_next = btlpm_pkg::ST_DONE;
                    end
                end
                else if (sts.at_end || (sts.child_none && sts.pool_full))
                begin
                    state_next = btlpm_pkg::ST_DONE;
                end
                else if (sts.child_none)
                begin
                    state_next = btlpm_pkg::ST_ALLOC;
                end
            end
            btlpm_pkg::ST_ALLOC:
            begin
                if (sts.at_end || sts.pool_full)
                begin
                    state_next = btlpm_pkg::ST_DONE;
                end
            end
            btlpm_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = btlpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = btlpm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            btlpm_pkg::ST_IDLE:
            begin
                cmd.load = s_tvalid;
            end
            btlpm_pkg::ST_WALK:
            begin
                if (sts.is_lookup)
                begin
                    cmd.record = 1'b1;
                    cmd.follow = !sts.at_end && !sts.child_none;
                end
                else if (sts.at_end)
                begin
                    cmd.commit = 1'b1;
                end
                else if (sts.child_none)
                begin
                    cmd.set_full = sts.pool_full;
                    cmd.alloc    = !sts.pool_full;
                end
                else
                begin
                    cmd.follow = 1'b1;
                end
            end
            btlpm_pkg::ST_ALLOC:
            begin
                cmd.fresh = 1'b1;
                if (sts.at_end)
                begin
                    cmd.commit = 1'b1;
                end
                else if (sts.pool_full)
                begin
                    cmd.fill     = 1'b1;
                    cmd.set_full = 1'b1;
                end
                else
                begin
                    cmd.alloc = 1'b1;
                end
            end
            btlpm_pkg::ST_DONE:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= btlpm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/btlpm_dp.sv @@
// Datapath for the trie walk: node memory, walk registers, node pool
// counter and output register. Depends on btlpm_pkg.
`timescale 1ns / 1ps

module btlpm_dp
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [btlpm_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tuser,
    output logic [btlpm_pkg::M_TDATA_W-1:0]    m_tdata,
    input  btlpm_pkg::dp_cmd_t                 cmd,
    output btlpm_pkg::dp_sts_t                 sts
);

    localparam int IW = btlpm_pkg::IDX_W;
    localparam int UW = btlpm_pkg::USED_W;
    localparam int DW = btlpm_pkg::DEPTH_W;
    localparam int AB = btlpm_pkg::ADDR_BITS;
    localparam int PW = btlpm_pkg::PORT_W;
    localparam int LW = btlpm_pkg::LEN_W;

    btlpm_pkg::node_t mem [btlpm_pkg::NODE_COUNT];

    logic             op_reg;
    logic [AB-1:0]    addr_reg;
    logic [DW-1:0]    len_reg;
    logic [PW-1:0]    rport_reg;
    logic [IW-1:0]    cur_reg;
    logic [DW-1:0]    depth_reg;
    logic [UW-1:0]    used_reg;
    logic             hit_reg;
    logic [PW-1:0]    best_reg;
    logic             full_reg;
    logic             root_init_reg;
    logic             rd_blank_reg;
    btlpm_pkg::node_t rd_q_reg;
    logic [btlpm_pkg::M_TDATA_W-1:0] out_reg;

    btlpm_pkg::node_t rd_node;
    btlpm_pkg::node_t base_node;
    btlpm_pkg::node_t wr_node;
    logic             cur_bit;
    logic [IW-1:0]    child;
    logic [IW-1:0]    new_idx;
    logic [IW-1:0]    rd_idx;
    logic             rd_en;
    logic             wr_en;
    logic [LW-1:0]    in_len;
    logic [DW-1:0]    in_len_sat;
    logic [btlpm_pkg::M_TDATA_W-1:0] out_next;

    assign rd_node  = rd_blank_reg ? '0 : rd_q_reg;
    assign cur_bit  = addr_reg[AB-1];
    assign child    = cur_bit ? rd_node.child1 : rd_node.child0;
    assign new_idx  = used_reg[IW-1:0];
    assign rd_en    = cmd.load || cmd.follow;
    assign rd_idx   = cmd.load ? '0 : child;
    assign wr_en    = cmd.alloc || cmd.commit || cmd.fill;

    assign in_len     = s_tdata[btlpm_pkg::RPORT_LSB-1:btlpm_pkg::LEN_LSB];
    assign in_len_sat = (in_len > LW'(AB)) ? DW'(AB) : DW'(in_len);

    assign sts.is_lookup  = (op_reg == btlpm_pkg::OP_LOOKUP);
    assign sts.at_end     = (depth_reg == len_reg);
    assign sts.child_none = (child == '0);
    assign sts.pool_full  = (used_reg == UW'(btlpm_pkg::NODE_COUNT));

    always_comb
    begin
        base_node = cmd.fresh ? '0 : rd_node;
        wr_node   = base_node;
        if (cmd.alloc)
        begin
            if (cur_bit)
            begin
                wr_node.child1 = new_idx;
            end
            else
            begin
                wr_node.child0 = new_idx;
            end
        end
        if (cmd.commit)
        begin
            wr_node.valid = 1'b1;
            wr_node.port  = rport_reg;
        end
    end

    always_comb
    begin
        out_next          = '0;
        out_next[0]       = hit_reg;
        out_next[PW:1]    = hit_reg ? best_reg : '0;
        out_next[PW+1]    = full_reg;
    end

    assign m_tdata = out_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cur_reg] <= wr_node;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= UW'(1);
            root_init_reg <= 1'b0;
            rd_blank_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.alloc)
            begin
                used_reg <= used_reg + UW'(1);
            end
            if (wr_en && (cur_reg == '0))
            begin
                root_init_reg <= 1'b1;
            end
            if (rd_en)
            begin
                rd_blank_reg <= (rd_idx == '0) && !root_init_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= s_tuser;
            addr_reg  <= s_tdata[AB-1:0];
            len_reg   <= (s_tuser == btlpm_pkg::OP_LOOKUP) ? DW'(AB) : in_len_sat;
            rport_reg <= s_tdata[btlpm_pkg::IN_BITS-1:btlpm_pkg::RPORT_LSB];
            cur_reg   <= '0;
            depth_reg <= '0;
            hit_reg   <= 1'b0;
            best_reg  <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.follow || cmd.alloc)
            begin
                addr_reg  <= addr_reg << 1;
                depth_reg <= depth_reg + DW'(1);
                cur_reg   <= cmd.alloc ? new_idx : child;
            end
            if (cmd.record && rd_node.valid)
            begin
                hit_reg  <= 1'b1;
                best_reg <= rd_node.port;
            end
            if (cmd.set_full)
            begin
                full_reg <= 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

endmodule

@@ hw/rtl/binary_trie_longest_prefix_match.sv @@
// Top level of the binary trie longest-prefix-match block for IPv4 routing.
// Joins btlpm_ctrl and btlpm_dp; depends on btlpm_pkg.
//
// Input stream: s_tuser selects insert (0) or lookup (1); s_tdata carries the
// address, prefix length and route port. Output stream: one result per item
// on m_tdata with found, out_port and status (1 = node pool full, route
// dropped). Each item walks the trie one address bit per cycle through the
// single-port node memory: the root is read at the transfer edge, then each
// level in turn. A lookup visits up to 33 levels, root included; an insert
// goes down to the level given by its prefix length (saturated at 32).
// Inserts that need new nodes write one node per cycle and need no extra reads.
// Items are handled one at a time; a new item is taken once the previous
// result sits in the output register, even if that result is still waiting.
// Each result load returns the block to idle before it takes the next item.
// Stalls on m_tready hold the result and stop the block before its next
// result. Reset empties the trie (root only, no routes) at once, with no
// clearing pass; non-root node entries are written when allocated.
`timescale 1ns / 1ps

module binary_trie_longest_prefix_match
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [31:0] address, [37:32] prefix_len, [45:38] route_port, [47:46] zero
    input  logic [btlpm_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] op
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] found, [8:1] out_port, [9] status, [15:10] zero
    output logic [btlpm_pkg::M_TDATA_W-1:0]  m_tdata
);

    btlpm_pkg::dp_cmd_t cmd;
    btlpm_pkg::dp_sts_t sts;

    btlpm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    btlpm_dp u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
